// ===== sv/vaff_pkg.sv =====
package vaff_pkg;

    localparam int MAX_PACKET_DEF    = 512;
    localparam int TABLE_ENTRIES_DEF = 4;
    localparam int MAX_TABLE         = 4;
    localparam int ADDR_W            = 48;
    localparam int CFG_IDX_W         = 3;
    localparam int RES_DEPTH         = 4;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_DEVICE_ADDR_0 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DEVICE_ADDR_1 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DEVICE_ADDR_2 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DEVICE_ADDR_3 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DEVICE_ENABLE = 3'd4;

    // frame check constants
    localparam logic [7:0]  FC_TYPE_MASK    = 8'h0C;
    localparam logic [3:0]  SUBTYPE_ACTION  = 4'd13;
    localparam logic [7:0]  CATEGORY_VENDOR = 8'd127;
    localparam logic [7:0]  OUI_0           = 8'd24;
    localparam logic [7:0]  OUI_1           = 8'd254;
    localparam logic [7:0]  OUI_2           = 8'd52;
    localparam logic [7:0]  ELEM_VENDOR     = 8'd221;
    localparam logic [7:0]  VENDOR_TYPE     = 8'd4;
    localparam logic [7:0]  ELEM_HDR_LEN    = 8'd5;
    localparam logic [15:0] RT_MIN_LEN      = 16'd8;

    // offsets into the frame behind the radiotap header
    localparam logic [15:0] K_FC          = 16'd0;
    localparam logic [15:0] K_SRC_FIRST   = 16'd10;
    localparam logic [15:0] K_SRC_LAST    = 16'd15;
    localparam logic [15:0] K_CATEGORY    = 16'd24;
    localparam logic [15:0] K_OUI_0       = 16'd25;
    localparam logic [15:0] K_OUI_1       = 16'd26;
    localparam logic [15:0] K_OUI_2       = 16'd27;
    localparam logic [15:0] K_ELEM_ID     = 16'd32;
    localparam logic [15:0] K_ELEM_LEN    = 16'd33;
    localparam logic [15:0] K_VENDOR_TYPE = 16'd37;
    localparam logic [15:0] K_VERSION     = 16'd38;
    localparam logic [15:0] K_PAYLOAD     = 16'd39;

    typedef struct packed {
        logic                 kind;
        logic [7:0]           payload_byte;
        logic [7:0]           payload_index;
        logic                 accepted;
        logic [ADDR_W-1:0]    source_addr;
        logic [7:0]           signal_level;
        logic [7:0]           vendor_version;
        logic [7:0]           payload_length;
        logic [MAX_TABLE-1:0] match_mask;
        logic                 truncated;
        logic                 last_result;
    } result_t;

    typedef struct packed {
        logic [1:0] count;
        result_t    first;
        result_t    second;
    } push_t;

    // byte offset of the antenna signal field for the low present bits
    function automatic logic [4:0] walk_offset(input logic [5:0] p);
        logic [5:0] i;
        i = 6'd8;
        if (p[0]) i = i + 6'd8;
        if (p[1]) i = i + 6'd1;
        if (p[2]) i = i + 6'd1;
        if (p[3])
        begin
            i = (i + 6'd1) & 6'h3E;
            i = i + 6'd4;
        end
        if (p[4]) i = i + 6'd1;
        return i[4:0];
    endfunction

endpackage

// ===== sv/vaff_device_table.sv =====
module vaff_device_table #(
    parameter int TABLE_ENTRIES = vaff_pkg::TABLE_ENTRIES_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_valid,
    input  logic [vaff_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [vaff_pkg::ADDR_W-1:0]    cfg_data,
    input  logic [vaff_pkg::ADDR_W-1:0]    addr,
    output logic [vaff_pkg::MAX_TABLE-1:0] mask
);
    import vaff_pkg::*;

    logic [ADDR_W-1:0]        addr_reg [TABLE_ENTRIES];
    logic [TABLE_ENTRIES-1:0] enable_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg <= '0;
        end
        else if (cfg_valid && cfg_index == REG_DEVICE_ENABLE)
        begin
            enable_reg <= cfg_data[TABLE_ENTRIES-1:0];
        end
    end

    for (genvar i = 0; i < MAX_TABLE; i++)
    begin : g_entry
        if (i < TABLE_ENTRIES)
        begin : g_used
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    addr_reg[i] <= '0;
                end
                else if (cfg_valid && cfg_index == CFG_IDX_W'(i))
                begin
                    addr_reg[i] <= cfg_data;
                end
            end
            assign mask[i] = enable_reg[i] && (addr_reg[i] == addr);
        end
        else
        begin : g_unused
            assign mask[i] = 1'b0;
        end
    end

endmodule

// ===== sv/vaff_parser.sv =====
module vaff_parser #(
    parameter int MAX_PACKET = vaff_pkg::MAX_PACKET_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [7:0]                     rx_byte,
    input  logic                           end_of_packet,
    input  logic                           space_ok,
    output logic [vaff_pkg::ADDR_W-1:0]    source_next,
    input  logic [vaff_pkg::MAX_TABLE-1:0] match_mask,
    output vaff_pkg::push_t                push
);
    import vaff_pkg::*;

    localparam int POS_W = $clog2(MAX_PACKET + 1);

    logic              stage_v_reg;
    logic [7:0]        stage_byte_reg;
    logic              stage_eop_reg;

    logic [POS_W-1:0]  pos_reg,     pos_next;
    logic [15:0]       rl_reg,      rl_next;
    logic [5:0]        present_reg, present_next;
    logic [4:0]        sig_off_reg, sig_off_next;
    logic [7:0]        sig_reg,     sig_next;
    logic [ADDR_W-1:0] src_reg,     src_next;
    logic [7:0]        decl_reg,    decl_next;
    logic [7:0]        ver_reg,     ver_next;
    logic [7:0]        lnz_reg,     lnz_next;
    logic              checks_reg,  checks_next;

    logic        advance;
    logic        emit;
    logic [7:0]  idx;
    logic [7:0]  b;
    logic [15:0] k;
    logic [16:0] need;
    logic        trunc;
    logic        acc;
    result_t     r_pay;
    result_t     r_sum;

    assign advance  = stage_v_reg && space_ok;
    assign in_ready = !stage_v_reg || advance;
    assign b        = stage_byte_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_v_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            stage_v_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            stage_byte_reg <= rx_byte;
            stage_eop_reg  <= end_of_packet;
        end
    end

    always_comb
    begin
        pos_next     = pos_reg;
        rl_next      = rl_reg;
        present_next = present_reg;
        sig_off_next = sig_off_reg;
        sig_next     = sig_reg;
        src_next     = src_reg;
        decl_next    = decl_reg;
        ver_next     = ver_reg;
        lnz_next     = lnz_reg;
        checks_next  = checks_reg;
        emit         = 1'b0;
        idx          = '0;
        k            = 16'(pos_reg) - rl_reg;

        // bytes past the packet limit are dropped
        if (pos_reg < POS_W'(MAX_PACKET))
        begin
            pos_next = pos_reg + POS_W'(1);
            if (pos_reg == POS_W'(2))
            begin
                rl_next = {8'h00, b};
            end
            if (pos_reg == POS_W'(3))
            begin
                rl_next = {b, rl_reg[7:0]};
                if (rl_next < RT_MIN_LEN) checks_next = 1'b0;
            end
            if (pos_reg == POS_W'(4))
            begin
                present_next = b[5:0];
                sig_off_next = walk_offset(b[5:0]);
            end
            if (pos_reg >= POS_W'(8) && present_reg[5] && pos_reg == POS_W'(sig_off_reg))
            begin
                sig_next = b;
            end
            if (pos_reg >= POS_W'(8) && rl_reg >= RT_MIN_LEN && 16'(pos_reg) >= rl_reg)
            begin
                if (k == K_FC && ((b & FC_TYPE_MASK) != 8'h00 || b[7:4] != SUBTYPE_ACTION))
                begin
                    checks_next = 1'b0;
                end
                if (k >= K_SRC_FIRST && k <= K_SRC_LAST)
                begin
                    src_next = {src_reg[ADDR_W-9:0], b};
                end
                if ((k == K_CATEGORY && b != CATEGORY_VENDOR) ||
                    (k == K_OUI_0 && b != OUI_0) ||
                    (k == K_OUI_1 && b != OUI_1) ||
                    (k == K_OUI_2 && b != OUI_2) ||
                    (k == K_ELEM_ID && b != ELEM_VENDOR) ||
                    (k == K_VENDOR_TYPE && b != VENDOR_TYPE))
                begin
                    checks_next = 1'b0;
                end
                if (k == K_ELEM_LEN)
                begin
                    decl_next = (b >= ELEM_HDR_LEN) ? b - ELEM_HDR_LEN : 8'd0;
                end
                if (k == K_VERSION)
                begin
                    ver_next = b;
                end
                if (k >= K_PAYLOAD && k < K_PAYLOAD + 16'(decl_reg) && checks_next)
                begin
                    emit = 1'b1;
                    idx  = 8'(k - K_PAYLOAD);
                    if (b != 8'h00) lnz_next = idx + 8'd1;
                end
            end
        end

        need  = 17'(rl_next) + 17'(K_PAYLOAD) + 17'(decl_next);
        trunc = checks_next && (17'(pos_next) < need);
        acc   = checks_next && !trunc;
    end

    assign source_next = src_next;

    always_comb
    begin
        r_pay               = '0;
        r_pay.payload_byte  = b;
        r_pay.payload_index = idx;
        r_pay.last_result   = !stage_eop_reg;

        r_sum                = '0;
        r_sum.kind           = 1'b1;
        r_sum.accepted       = acc;
        r_sum.source_addr    = acc ? src_next : '0;
        r_sum.signal_level   = sig_next;
        r_sum.vendor_version = acc ? ver_next : 8'd0;
        r_sum.payload_length = acc ? lnz_next : 8'd0;
        r_sum.match_mask     = acc ? match_mask : '0;
        r_sum.truncated      = trunc;
        r_sum.last_result    = 1'b1;

        push        = '0;
        push.first  = emit ? r_pay : r_sum;
        push.second = r_sum;
        if (advance)
        begin
            push.count = 2'(emit) + 2'(stage_eop_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg     <= '0;
            rl_reg      <= '0;
            present_reg <= '0;
            sig_off_reg <= '0;
            sig_reg     <= '0;
            src_reg     <= '0;
            decl_reg    <= '0;
            ver_reg     <= '0;
            lnz_reg     <= '0;
            checks_reg  <= 1'b1;
        end
        else if (advance)
        begin
            if (stage_eop_reg)
            begin
                // drop all packet state after the summary
                pos_reg     <= '0;
                rl_reg      <= '0;
                present_reg <= '0;
                sig_off_reg <= '0;
                sig_reg     <= '0;
                src_reg     <= '0;
                decl_reg    <= '0;
                ver_reg     <= '0;
                lnz_reg     <= '0;
                checks_reg  <= 1'b1;
            end
            else
            begin
                pos_reg     <= pos_next;
                rl_reg      <= rl_next;
                present_reg <= present_next;
                sig_off_reg <= sig_off_next;
                sig_reg     <= sig_next;
                src_reg     <= src_next;
                decl_reg    <= decl_next;
                ver_reg     <= ver_next;
                lnz_reg     <= lnz_next;
                checks_reg  <= checks_next;
            end
        end
    end

`ifndef SYNTHESIS
    a_clear_after_summary: assert property (@(posedge clk) disable iff (!rst_n)
        advance && stage_eop_reg |=> pos_reg == '0 && checks_reg)
        else $error("packet state not cleared after summary");

    a_pair_order: assert property (@(posedge clk) disable iff (!rst_n)
        push.count == 2'd2 |-> !push.first.kind && push.second.kind)
        else $error("payload word must precede summary word");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> stage_v_reg && !space_ok)
        else $error("input stalled without a full result queue");
`endif

endmodule

// ===== sv/vaff_result_fifo.sv =====
module vaff_result_fifo #(
    parameter int DEPTH = vaff_pkg::RES_DEPTH
) (
    input  logic              clk,
    input  logic              rst_n,
    input  vaff_pkg::push_t   push,
    output logic              space_ok,
    output logic              out_valid,
    input  logic              out_ready,
    output vaff_pkg::result_t out_data
);
    import vaff_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    result_t          mem_reg [DEPTH];
    logic [PTR_W-1:0] head_reg, head_next;
    logic [PTR_W-1:0] tail_reg, tail_next;
    logic [PTR_W-1:0] tail_plus;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             pop;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    assign pop       = out_valid && out_ready;
    assign out_valid = count_reg != '0;
    assign out_data  = mem_reg[head_reg];
    assign space_ok  = count_reg <= CNT_W'(DEPTH - 2);
    assign tail_plus = ptr_inc(tail_reg);

    always_comb
    begin
        head_next  = pop ? ptr_inc(head_reg) : head_reg;
        case (push.count)
            2'd1:    tail_next = tail_plus;
            2'd2:    tail_next = ptr_inc(tail_plus);
            default: tail_next = tail_reg;
        endcase
        count_next = count_reg + CNT_W'(push.count) - CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
        begin
            mem_reg[tail_reg] <= push.first;
        end
        if (push.count == 2'd2)
        begin
            mem_reg[tail_plus] <= push.second;
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("result queue count out of range");

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push.count != 2'd0 |-> space_ok)
        else $error("push into result queue without room");

    a_head_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(head_reg))
        else $error("head advanced while output stalled");
`endif

endmodule

// ===== sv/vendor_action_frame_filter.sv =====
// An accepted byte is held in the input register and then written into the result queue.
// Throughput: one byte per cycle unless stalled; a final byte with payload gives two words,
// which leave one per cycle while out_ready is high through a four-word result queue.
// The input register stalls only when the result queue has room for fewer than two words.
// Reset (rst_n low, asynchronous): packet state cleared, address table and enables
// zeroed, result queue emptied.
module vendor_action_frame_filter #(
    parameter int MAX_PACKET    = vaff_pkg::MAX_PACKET_DEF,
    parameter int TABLE_ENTRIES = vaff_pkg::TABLE_ENTRIES_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [7:0]                     rx_byte,
    input  logic                           end_of_packet,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic                           kind,
    output logic [7:0]                     payload_byte,
    output logic [7:0]                     payload_index,
    output logic                           accepted,
    output logic [vaff_pkg::ADDR_W-1:0]    source_addr,
    output logic [7:0]                     signal_level,
    output logic [7:0]                     vendor_version,
    output logic [7:0]                     payload_length,
    output logic [vaff_pkg::MAX_TABLE-1:0] match_mask,
    output logic                           truncated,
    output logic                           last_result,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [vaff_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [vaff_pkg::ADDR_W-1:0]    cfg_data
);
    import vaff_pkg::*;

    logic [ADDR_W-1:0]    source_next;
    logic [MAX_TABLE-1:0] mask;
    logic                 space_ok;
    push_t                push;
    result_t              out_data;

    assign cfg_ready = 1'b1;

    vaff_device_table #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_table (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .addr      (source_next),
        .mask      (mask)
    );

    vaff_parser #(
        .MAX_PACKET (MAX_PACKET)
    ) u_parser (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .rx_byte       (rx_byte),
        .end_of_packet (end_of_packet),
        .space_ok      (space_ok),
        .source_next   (source_next),
        .match_mask    (mask),
        .push          (push)
    );

    vaff_result_fifo #(
        .DEPTH (RES_DEPTH)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .space_ok  (space_ok),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    assign kind           = out_data.kind;
    assign payload_byte   = out_data.payload_byte;
    assign payload_index  = out_data.payload_index;
    assign accepted       = out_data.accepted;
    assign source_addr    = out_data.source_addr;
    assign signal_level   = out_data.signal_level;
    assign vendor_version = out_data.vendor_version;
    assign payload_length = out_data.payload_length;
    assign match_mask     = out_data.match_mask;
    assign truncated      = out_data.truncated;
    assign last_result    = out_data.last_result;

endmodule
